FILE: sv/ufs_pkg.sv
// Package with the types, sizes and helper functions of the union-find-by-size unit.
package ufs_pkg;

  localparam int NODES      = 1024;
  localparam int NODE_W     = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int SIZE_W     = $clog2(NODES + 1);
  localparam int FLD_NODE_W = 10;
  localparam int FLD_SIZE_W = 11;
  localparam int SIZE_MAX   = (1 << FLD_SIZE_W) - 1;

  localparam logic REQ_QUERY = 1'b0;
  localparam logic REQ_LINK  = 1'b1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [SIZE_W-1:0] size_t;

  typedef struct packed {
    logic                  req_type;
    logic [FLD_NODE_W-1:0] node_a;
    logic [FLD_NODE_W-1:0] node_b;
  } req_t;

  typedef struct packed {
    logic                  already_joined;
    logic                  merged;
    logic [FLD_NODE_W-1:0] root_of_a;
    logic [FLD_SIZE_W-1:0] set_size;
  } res_t;

  // Table access for one cycle: one read address per table and one write per table.
  typedef struct packed {
    node_t par_raddr;
    node_t size_raddr;
    logic  par_we;
    node_t par_waddr;
    node_t par_wdata;
    logic  size_we;
    node_t size_waddr;
    size_t size_wdata;
  } tbl_cmd_t;

  // An index past the last node saturates to the last node.
  function automatic node_t clamp_node(logic [FLD_NODE_W-1:0] v);
    node_t r;
    if (32'(v) >= NODES) begin
      r = NODE_W'(NODES - 1);
    end else begin
      r = NODE_W'(v);
    end
    return r;
  endfunction

  function automatic logic [FLD_SIZE_W-1:0] sat_size(size_t s);
    logic [FLD_SIZE_W-1:0] r;
    if (32'(s) > SIZE_MAX) begin
      r = FLD_SIZE_W'(SIZE_MAX);
    end else begin
      r = FLD_SIZE_W'(s);
    end
    return r;
  endfunction

endpackage

FILE: sv/ufs_tables.sv
// Parent and size memories of the union-find-by-size unit, with the clearing sweep after reset.
module ufs_tables (
  input  logic             clk,
  input  logic             rst,
  input  ufs_pkg::tbl_cmd_t cmd,
  output ufs_pkg::node_t   par_rdata,
  output ufs_pkg::size_t   size_rdata,
  output logic             clearing
);
  import ufs_pkg::*;

  node_t par_mem  [NODES];
  size_t size_mem [NODES];
  node_t clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (32'(clr_idx) == NODES - 1) begin
        clearing <= 1'b0;
      end
    end
  end

  // During the sweep every node becomes its own root of size one.
  always_ff @(posedge clk) begin
    if (clearing) begin
      par_mem[clr_idx] <= clr_idx;
    end else if (cmd.par_we) begin
      par_mem[cmd.par_waddr] <= cmd.par_wdata;
    end
    par_rdata <= par_mem[cmd.par_raddr];
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      size_mem[clr_idx] <= SIZE_W'(1);
    end else if (cmd.size_we) begin
      size_mem[cmd.size_waddr] <= cmd.size_wdata;
    end
    size_rdata <= size_mem[cmd.size_raddr];
  end

endmodule

FILE: sv/union_find_by_size_unit.sv
// A new word is accepted only in the idle state once the sweep is over, so the unit takes no new
// word until the current result is out; the time per word is set by the walk up the parent memory,
// one read per tree level.
// Results appear on res for exactly one cycle with done high; the receiver cannot stall.
// Reset: synchronous; afterwards busy stays high while both memories
// are swept to every node being its own root of size one.
module union_find_by_size_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ufs_pkg::req_t req,
  output logic          done,
  output ufs_pkg::res_t res
);
  import ufs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_FIND_A, S_FIND_B, S_LINK} state_t;

  state_t   state;
  logic     link_reg;
  node_t    b_reg;
  node_t    cur;
  node_t    root_a;
  size_t    size_a;
  tbl_cmd_t cmd;
  node_t    par_rdata;
  size_t    size_rdata;
  logic     tbl_clearing;

  logic     at_root;
  logic     joined;
  logic     do_merge;
  logic     a_is_big;
  node_t    big;
  node_t    small_root;
  size_t    sum;

  ufs_tables u_tables (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .par_rdata  (par_rdata),
    .size_rdata (size_rdata),
    .clearing   (tbl_clearing)
  );

  assign busy     = (state != S_IDLE) || tbl_clearing;
  assign at_root  = (par_rdata == cur);
  // In the link state cur holds the root of b and size_rdata its size.
  assign joined   = (root_a == cur);
  assign do_merge = (link_reg == REQ_LINK) && !joined;
  assign a_is_big = !(size_a < size_rdata);
  assign big        = a_is_big ? root_a : cur;
  assign small_root = a_is_big ? cur : root_a;
  assign sum        = SIZE_W'({1'b0, size_a} + {1'b0, size_rdata});

  always_comb begin
    cmd            = '0;
    cmd.par_waddr  = small_root;
    cmd.par_wdata  = big;
    cmd.size_waddr = big;
    cmd.size_wdata = sum;
    case (state)
      S_IDLE: begin
        cmd.par_raddr  = clamp_node(req.node_a);
        cmd.size_raddr = root_a;
      end
      S_FIND_A: begin
        cmd.par_raddr  = at_root ? b_reg : par_rdata;
        cmd.size_raddr = cur;
      end
      S_FIND_B: begin
        cmd.par_raddr  = par_rdata;
        cmd.size_raddr = at_root ? cur : root_a;
      end
      S_LINK: begin
        cmd.par_raddr  = cur;
        cmd.size_raddr = cur;
        cmd.par_we     = do_merge;
        cmd.size_we    = do_merge;
      end
      default: begin
        cmd.par_raddr  = cur;
        cmd.size_raddr = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && !tbl_clearing) begin
            link_reg <= req.req_type;
            b_reg    <= clamp_node(req.node_b);
            cur      <= clamp_node(req.node_a);
            state    <= S_FIND_A;
          end
        end
        S_FIND_A: begin
          if (at_root) begin
            root_a <= cur;
            cur    <= b_reg;
            state  <= S_FIND_B;
          end else begin
            cur <= par_rdata;
          end
        end
        S_FIND_B: begin
          if (at_root) begin
            size_a <= size_rdata;
            state  <= S_LINK;
          end else begin
            cur <= par_rdata;
          end
        end
        S_LINK: begin
          done               <= 1'b1;
          res.already_joined <= joined;
          res.merged         <= do_merge;
          res.root_of_a      <= FLD_NODE_W'(do_merge ? big : root_a);
          res.set_size       <= sat_size(do_merge ? sum : size_a);
          state              <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_link: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_LINK))
    else $error("result strobe without a link step");

  a_busy_in_clear: assert property (@(posedge clk) disable iff (rst)
    tbl_clearing |-> busy)
    else $error("unit ready during the clearing sweep");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the unit busy");

  a_merge_excl: assert property (@(posedge clk) disable iff (rst)
    (done && res.merged) |-> (!res.already_joined && link_reg == REQ_LINK))
    else $error("merge reported on a query or within one set");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.par_we || cmd.size_we) |-> (state == S_LINK))
    else $error("table write outside the link step");

endmodule
